// ----- rtl/core/poi_pkg.sv -----
// ----------------------------------------------------------------------------
// Planar odometry integrator package
// Item types, sequencer states, arithmetic widths and constant tables shared
// by the pose integrator and its arithmetic units.
// ----------------------------------------------------------------------------
package poi_pkg;

    // Width of the CORDIC datapath (Q1.30 values with headroom).
    localparam int CORD_W = 34;
    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 22;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // CORDIC gain compensation, 0.6072529 in Q1.30.
    localparam logic signed [CORD_W-1:0] CORDIC_K = 34'sd652032874;

    // round(2^64 / (2*pi*1e9)) split as HI * 2^16 + LO.
    localparam logic [MUL_B_W-1:0] HEAD_K_HI = 22'd44798;
    localparam logic [MUL_B_W-1:0] HEAD_K_LO = 22'd8775;

    typedef struct packed {
        logic signed [15:0] forward_speed;
        logic signed [15:0] lateral_speed;
        logic signed [15:0] yaw_rate;
        logic        [19:0] elapsed_time;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] pos_x;
        logic signed [63:0] pos_y;
        logic        [31:0] heading;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ROT1,
        S_M_VC,
        S_M_LS,
        S_M_VS,
        S_M_LC,
        S_M_QX,
        S_RND_Y,
        S_M_QY,
        S_M_YAW,
        S_ABS,
        S_M_K1,
        S_M_K2,
        S_HSUM,
        S_HUPD,
        S_ROT2_GO,
        S_ROT2,
        S_DONE
    } t_state;

    // Arctangent table, round(atan(2^-i) * 2^32 / (2*pi)).
    function automatic logic [29:0] atan_entry(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd41;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            5'd28:   v = 30'd3;
            5'd29:   v = 30'd1;
            5'd30:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Saturating add of a displacement to a 64-bit position.
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [42:0] d);
        logic [64:0] s;
        logic [63:0] r;
        s = {a[63], a} + {{22{d[42]}}, d};
        if (s[64] != s[63]) begin
            r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

    // Round a Q1.30 value to Q1.15 and clamp to the 16-bit range.
    function automatic logic [15:0] to_q15(input logic [CORD_W-1:0] v);
        logic [CORD_W:0]   s;
        logic [CORD_W-15:0] q;
        logic [15:0]       r;
        s = {v[CORD_W-1], v} + (CORD_W+1)'(16384);
        q = s[CORD_W:15];
        if (!q[CORD_W-15] && (q[CORD_W-16:15] != '0)) begin
            r = 16'h7FFF;
        end else if (q[CORD_W-15] && (q[CORD_W-16:15] != '1)) begin
            r = 16'h8000;
        end else begin
            r = q[15:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/poi_cordic.sv -----
// ----------------------------------------------------------------------------
// Iterative CORDIC sine and cosine
// Rotation-mode CORDIC on Q1.30 values, one micro-rotation per clock, with
// the angle folded into the right half plane before the first step.
// ----------------------------------------------------------------------------
module poi_cordic import poi_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [31:0]              i_angle,
    output logic                     o_done,
    output logic signed [CORD_W-1:0] o_cos,
    output logic signed [CORD_W-1:0] o_sin
);

    localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                     r_run, r_fin, r_done, r_flip;
    logic [CW-1:0]            r_i;
    logic signed [CORD_W-1:0] r_x, r_y, r_z, r_cos, r_sin;

    logic                     n_flip;
    logic [31:0]              n_angle;
    logic signed [CORD_W-1:0] n_x, n_y, n_z, xs, ys, t;
    logic [31:0]              fold;

    // Angles outside [-90, 90) degrees get half a turn added and the results
    // negated at the end.
    always_comb begin
        fold    = i_angle + 32'h4000_0000;
        n_flip  = fold[31];
        n_angle = n_flip ? (i_angle ^ 32'h8000_0000) : i_angle;
    end

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        t  = {4'd0, atan_entry(5'(r_i))};
        if (!r_z[CORD_W-1]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - t;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_i == CW'(STEPS - 1))) begin
                r_run <= 1'b0;
                r_fin <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_K;
            r_y    <= '0;
            r_z    <= {{(CORD_W-32){n_angle[31]}}, n_angle};
            r_i    <= '0;
            r_flip <= n_flip;
        end else if (r_run) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_i <= r_i + 1'b1;
        end
        if (r_fin) begin
            r_cos <= r_flip ? -r_x : r_x;
            r_sin <= r_flip ? -r_y : r_y;
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

// ----- rtl/core/poi_mul.sv -----
// ----------------------------------------------------------------------------
// Shared signed multiplier
// One registered signed multiplication per clock for every product the
// integrator needs.
// ----------------------------------------------------------------------------
module poi_mul import poi_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [PROD_W-1:0]  o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/core/planar_odometry_integrator.sv -----
// ----------------------------------------------------------------------------
// Planar odometry integrator
// Dead-reckoning pose integration from body velocity samples.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one velocity sample per transfer (forward
// and lateral speed in mm/s, yaw rate in mrad/s, elapsed time in us). Each
// sample produces exactly one pose on the output channel: x and y position in
// nm (saturating), the binary-angle heading and the yaw quaternion z and w.
// The block works on one sample at a time. The CORDIC unit runs twice per
// sample, once for the old heading and once for the half new heading, and a
// single multiplier does the nine products in between; the CORDIC iterations
// dominate the time taken per sample. o_in_stall is high while a sample is
// in progress. A finished pose waits in the output register while the
// receiver stalls, and the next sample may be taken and computed meanwhile;
// its pose is held back until the register frees up. Reset clears the
// position and heading to zero and empties the output register.
// ----------------------------------------------------------------------------
module planar_odometry_integrator import poi_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_state r_state, n_state;

    // Latched sample.
    logic signed [15:0] r_v, r_l, r_w;
    logic        [19:0] r_dt;

    // Displacement pipeline registers.
    logic signed [47:0] r_rx, r_ry;
    logic signed [35:0] r_qx, r_qy;
    logic        [42:0] r_dx, r_dy;

    // Heading step registers.
    logic               r_neg;
    logic        [35:0] r_m;
    logic        [52:0] r_hsum;

    // Pose state.
    logic        [63:0] r_x, r_y;
    logic        [31:0] r_head;

    // Output register.
    logic               r_ovalid, n_ovalid;
    t_out_item          r_out;

    // Shared unit interfaces.
    logic                      cord_start;
    logic [31:0]               cord_angle;
    logic                      cord_done;
    logic signed [CORD_W-1:0]  cord_cos, cord_sin;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic in_xfer, out_xfer, out_free;
    logic [48:0] rnd_x, rnd_y;
    logic [58:0] rnd_prod;
    logic [36:0] yaw_p, yaw_abs;
    logic [31:0] head_step;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_ovalid && !i_out_stall;
    assign out_free = !r_ovalid || !i_out_stall;

    poi_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_angle (cord_angle),
        .o_done  (cord_done),
        .o_cos   (cord_cos),
        .o_sin   (cord_sin)
    );

    poi_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_ROT1;
            S_ROT1:    if (cord_done) n_state = S_M_VC;
            S_M_VC:    n_state = S_M_LS;
            S_M_LS:    n_state = S_M_VS;
            S_M_VS:    n_state = S_M_LC;
            S_M_LC:    n_state = S_M_QX;
            S_M_QX:    n_state = S_RND_Y;
            S_RND_Y:   n_state = S_M_QY;
            S_M_QY:    n_state = S_M_YAW;
            S_M_YAW:   n_state = S_ABS;
            S_ABS:     n_state = S_M_K1;
            S_M_K1:    n_state = S_M_K2;
            S_M_K2:    n_state = S_HSUM;
            S_HSUM:    n_state = S_HUPD;
            S_HUPD:    n_state = S_ROT2_GO;
            S_ROT2_GO: n_state = S_ROT2;
            S_ROT2:    if (cord_done) n_state = S_DONE;
            S_DONE:    if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, CORDIC launch and multiplier operands.
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        cord_start = 1'b0;
        cord_angle = r_head;
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            S_IDLE: begin
                cord_start = i_in_valid;
            end
            S_ROT2_GO: begin
                cord_start = 1'b1;
                cord_angle = {1'b0, r_head[31:1]};
            end
            S_M_VC: begin
                mul_a = MUL_A_W'(cord_cos);
                mul_b = MUL_B_W'(r_v);
            end
            S_M_LS: begin
                mul_a = MUL_A_W'(cord_sin);
                mul_b = MUL_B_W'(r_l);
            end
            S_M_VS: begin
                mul_a = MUL_A_W'(cord_sin);
                mul_b = MUL_B_W'(r_v);
            end
            S_M_LC: begin
                mul_a = MUL_A_W'(cord_cos);
                mul_b = MUL_B_W'(r_l);
            end
            S_M_QX: begin
                mul_a = r_qx;
                mul_b = {2'b00, r_dt};
            end
            S_M_QY: begin
                mul_a = r_qy;
                mul_b = {2'b00, r_dt};
            end
            S_M_YAW: begin
                mul_a = MUL_A_W'(r_w);
                mul_b = {2'b00, r_dt};
            end
            S_M_K1: begin
                mul_a = r_m;
                mul_b = HEAD_K_HI;
            end
            S_M_K2: begin
                mul_a = r_m;
                mul_b = HEAD_K_LO;
            end
            default: begin
                cord_start = 1'b0;
            end
        endcase
    end

    // Rounding helpers: Q.30 to Q.16 for the rotated velocity, and the
    // nanometre rounding of a time-scaled product.
    always_comb begin
        rnd_x     = {r_rx[47], r_rx} + 49'd8192;
        rnd_y     = {r_ry[47], r_ry} + 49'd8192;
        rnd_prod  = {prod[PROD_W-1], prod} + 59'd32768;
        yaw_p     = prod[36:0];
        yaw_abs   = yaw_p[36] ? (37'd0 - yaw_p) : yaw_p;
        head_step = r_neg ? (32'd0 - r_hsum[47:16]) : r_hsum[47:16];
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (out_xfer) begin
            n_ovalid = 1'b0;
        end
        if ((r_state == S_DONE) && out_free) begin
            n_ovalid = 1'b1;
        end
    end

    // Control state and pose accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_head   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (r_state == S_M_QY) begin
                r_x <= sat_add(r_x, r_dx);
            end
            if (r_state == S_ABS) begin
                r_y <= sat_add(r_y, r_dy);
            end
            if (r_state == S_HUPD) begin
                r_head <= r_head + head_step;
            end
        end
    end

    // Datapath registers, loaded step by step as the sequencer advances.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_v  <= i_in_item.forward_speed;
            r_l  <= i_in_item.lateral_speed;
            r_w  <= i_in_item.yaw_rate;
            r_dt <= i_in_item.elapsed_time;
        end
        case (r_state)
            S_M_LS: r_rx <= prod[47:0];
            S_M_VS: r_rx <= r_rx - prod[47:0];
            S_M_LC: begin
                r_ry <= prod[47:0];
                r_qx <= {rnd_x[48], rnd_x[48:14]};
            end
            S_M_QX: r_ry <= r_ry + prod[47:0];
            S_RND_Y: begin
                r_qy <= {rnd_y[48], rnd_y[48:14]};
                r_dx <= rnd_prod[58:16];
            end
            S_M_YAW: r_dy <= rnd_prod[58:16];
            S_ABS: begin
                r_neg <= yaw_p[36];
                r_m   <= yaw_abs[35:0];
            end
            S_M_K2: r_hsum <= prod[52:0];
            S_HSUM: r_hsum <= r_hsum + {16'd0, prod[52:16]} + 53'd32768;
            default: r_neg <= r_neg;
        endcase
        if ((r_state == S_DONE) && out_free) begin
            r_out.pos_x   <= r_x;
            r_out.pos_y   <= r_y;
            r_out.heading <= r_head;
            r_out.quat_z  <= to_q15(cord_sin);
            r_out.quat_w  <= to_q15(cord_cos);
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

endmodule

// ----- rtl/core/poi_checker.sv -----
// ----------------------------------------------------------------------------
// Planar odometry integrator port checker
// Watches the top-level ports for sequencing and output register behavior.
// ----------------------------------------------------------------------------
module poi_checker import poi_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("output result changed while stalled");

    // A sample does not finish at once, so the input is still busy after a transfer.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> ##1 o_in_stall)
        else $error("input accepted again too early");

    // A new result only appears as the sequencer finishes a sample.
    a_result_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(o_in_stall) && !o_in_stall))
        else $error("result appeared outside the end of a sample");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (.*);
